@@ design/vda_pkg.sv @@
// vda_pkg: shared types, constants and width helpers for the activity detector
// holds the payload structs, register indexes, reset values and pipeline control types
// no dependencies
package vda_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int GUARD_BITS_DEFAULT = 8;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int INT_BITS = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY_THRESHOLD = 2'd1;

	localparam logic [CFG_W-1:0] SMOOTHING_WEIGHT_RESET = 16'd6554;
	localparam logic [CFG_W-1:0] ACTIVITY_THRESHOLD_RESET = 16'd819;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] accel_x;
		logic signed [SAMPLE_WIDTH-1:0] accel_y;
		logic signed [SAMPLE_WIDTH-1:0] accel_z;
		logic                           last_in_batch;
	} sample_t;

	typedef struct packed {
		logic repetition_done;
		logic is_active;
	} result_t;

	// per-lane stage enables
	typedef struct packed {
		logic load;
		logic s1;
		logic s2;
	} pipe_ctrl_t;

	// item waiting in the merge stage
	typedef struct packed {
		logic valid;
		logic last;
	} merge_req_t;

	typedef enum logic {
		ST_RESTING = 1'b0,
		ST_ACTIVE  = 1'b1
	} act_state_t;

	// squared magnitude per axis, wraps at 64 bits
	function automatic int sq_width(input int guard_bits);
		int full;
		full = 2 * (SAMPLE_WIDTH + guard_bits + 1);
		return (full > 64) ? 64 : full;
	endfunction

	// sum of three squares, wraps at 64 bits
	function automatic int sum_width(input int guard_bits);
		int full;
		full = sq_width(guard_bits) + 2;
		return (full > 64) ? 64 : full;
	endfunction

endpackage

@@ design/vedba_activity_detector.sv @@
// vedba_activity_detector: top level, configuration registers and pipeline control
// instantiates three vda_lane axes and vda_merge; depends on vda_pkg
//
// usage: one accelerometer sample per input transaction (in_valid/in_stall, in_data).
// each axis has its own lane that tracks gravity with an exponential average and
// squares the dynamic remainder; the merge stage sums the axes, compares against the
// squared threshold and updates the resting/active state and the batch flag.
// only a sample marked last_in_batch makes an output transaction (out_valid/out_stall).
// a last sample passes the lane step registers and the result register to out_valid.
// the lanes hold one sample at a time; in_stall is high while a sample is in the
// lane multiplier and update steps and in the square step, and drops in the cycle the
// merge stage takes the sample, so the next one is accepted on that same edge.
// the result register lets the next sample enter while a result waits; if the
// receiver still stalls when the next last sample reaches the merge stage, that
// sample waits there and in_stall stays high.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// index 0 is the smoothing weight, index 1 the threshold, others are ignored.
// reset: gravity returns to (0, 0, 1 g), state to resting, batch flag and
// output valid to zero, registers to their defaults; no clearing pass is needed.
module vedba_activity_detector #(
	parameter int GUARD_BITS = vda_pkg::GUARD_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  vda_pkg::sample_t                in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output vda_pkg::result_t                out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vda_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vda_pkg::CFG_W-1:0]       cfg_data
);

	localparam int SQ_W = vda_pkg::sq_width(GUARD_BITS);

	logic [vda_pkg::CFG_W-1:0] alpha_q;
	logic [vda_pkg::CFG_W-1:0] threshold_q;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic last_s1;
	logic last_s2;
	logic last_s3;
	logic accept;
	logic fire;

	vda_pkg::pipe_ctrl_t ctrl;
	vda_pkg::merge_req_t req;

	logic [SQ_W-1:0] sq_x;
	logic [SQ_W-1:0] sq_y;
	logic [SQ_W-1:0] sq_z;

	assign cfg_ready = 1'b1;
	assign in_stall = v_s1 || v_s2 || (v_s3 && !fire);
	assign accept = in_valid && !in_stall;

	assign ctrl.load = accept;
	assign ctrl.s1 = v_s1;
	assign ctrl.s2 = v_s2;
	assign req.valid = v_s3;
	assign req.last = last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= vda_pkg::SMOOTHING_WEIGHT_RESET;
			threshold_q <= vda_pkg::ACTIVITY_THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vda_pkg::REG_SMOOTHING_WEIGHT:   alpha_q <= cfg_data;
				vda_pkg::REG_ACTIVITY_THRESHOLD: threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2 || (v_s3 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= in_data.last_in_batch;
		end
		if (v_s1) begin
			last_s2 <= last_s1;
		end
		if (v_s2) begin
			last_s3 <= last_s2;
		end
	end

	vda_lane #(
		.GUARD_BITS  (GUARD_BITS),
		.IS_VERTICAL (1'b0)
	) u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (in_data.accel_x),
		.alpha  (alpha_q),
		.sq_s3  (sq_x)
	);

	vda_lane #(
		.GUARD_BITS  (GUARD_BITS),
		.IS_VERTICAL (1'b0)
	) u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (in_data.accel_y),
		.alpha  (alpha_q),
		.sq_s3  (sq_y)
	);

	vda_lane #(
		.GUARD_BITS  (GUARD_BITS),
		.IS_VERTICAL (1'b1)
	) u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (in_data.accel_z),
		.alpha  (alpha_q),
		.sq_s3  (sq_z)
	);

	vda_merge #(
		.GUARD_BITS (GUARD_BITS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.sq_x      (sq_x),
		.sq_y      (sq_y),
		.sq_z      (sq_z),
		.threshold (threshold_q),
		.out_stall (out_stall),
		.fire      (fire),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

@@ design/vda_lane.sv @@
// vda_lane: one axis of the detector, gravity tracking and squared dynamic magnitude
// three pipeline steps: weighted difference, gravity update with remainder, square
// depends on vda_pkg
module vda_lane #(
	parameter int GUARD_BITS = vda_pkg::GUARD_BITS_DEFAULT,
	parameter bit IS_VERTICAL = 1'b0
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  vda_pkg::pipe_ctrl_t                           ctrl,
	input  logic signed [vda_pkg::SAMPLE_WIDTH-1:0]       sample,
	input  logic [vda_pkg::CFG_W-1:0]                     alpha,
	output logic [vda_pkg::sq_width(GUARD_BITS)-1:0]      sq_s3
);

	localparam int SW = vda_pkg::SAMPLE_WIDTH;
	localparam int G_W = SW + GUARD_BITS;
	localparam int D_W = G_W + 1;
	localparam int P_W = D_W + vda_pkg::CFG_W + 1;
	localparam int R_W = P_W - vda_pkg::CFG_W;
	localparam int S_W = R_W + 1;
	localparam int SQ_W = vda_pkg::sq_width(GUARD_BITS);
	localparam int FRAC_BITS = SW - vda_pkg::INT_BITS + GUARD_BITS;
	localparam logic signed [G_W-1:0] GRAV_ONE = G_W'(1) << FRAC_BITS;
	localparam logic signed [G_W-1:0] GRAV_RESET = IS_VERTICAL ? GRAV_ONE : '0;
	localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(1) << (vda_pkg::CFG_W - 1);

	logic signed [G_W-1:0] grav_q;
	logic signed [G_W-1:0] a_ext;
	logic signed [D_W-1:0] diff;
	logic signed [P_W-1:0] prod;
	logic signed [P_W-1:0] prod_s1;
	logic signed [SW-1:0]  sample_s1;

	logic signed [P_W-1:0] rounded;
	logic signed [R_W-1:0] step;
	logic signed [S_W-1:0] gsum;
	logic signed [G_W-1:0] grav_next;
	logic signed [G_W-1:0] a_ext_s1;
	logic signed [D_W-1:0] remainder;
	logic [D_W-1:0]        mag;
	logic [D_W-1:0]        mag_s2;
	logic [2*D_W-1:0]      sq_full;

	// step 1: alpha times (sample - gravity)
	assign a_ext = G_W'(sample) <<< GUARD_BITS;
	assign diff = D_W'(a_ext) - D_W'(grav_q);
	assign prod = P_W'(diff) * P_W'($signed({1'b0, alpha}));

	// step 2: rounded update, saturated to the gravity width
	assign rounded = prod_s1 + ROUND_HALF;
	assign step = R_W'(rounded >>> vda_pkg::CFG_W);
	assign gsum = S_W'(grav_q) + S_W'(step);

	always_comb begin
		if (gsum[S_W-1:G_W-1] == '0 || gsum[S_W-1:G_W-1] == '1) begin
			grav_next = gsum[G_W-1:0];
		end else if (gsum[S_W-1]) begin
			grav_next = {1'b1, {(G_W-1){1'b0}}};
		end else begin
			grav_next = {1'b0, {(G_W-1){1'b1}}};
		end
	end

	assign a_ext_s1 = G_W'(sample_s1) <<< GUARD_BITS;
	assign remainder = D_W'(a_ext_s1) - D_W'(grav_next);
	assign mag = remainder[D_W-1] ? unsigned'(-remainder) : unsigned'(remainder);

	// step 3: square
	assign sq_full = mag_s2 * mag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= GRAV_RESET;
		end else if (ctrl.s1) begin
			grav_q <= grav_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prod_s1 <= prod;
			sample_s1 <= sample;
		end
		if (ctrl.s1) begin
			mag_s2 <= mag;
		end
		if (ctrl.s2) begin
			sq_s3 <= sq_full[SQ_W-1:0];
		end
	end

endmodule

@@ design/vda_merge.sv @@
// vda_merge: sums the lane squares, runs the resting/active machine and the batch flag
// also holds the result register toward the output channel
// depends on vda_pkg
module vda_merge #(
	parameter int GUARD_BITS = vda_pkg::GUARD_BITS_DEFAULT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  vda_pkg::merge_req_t                      req,
	input  logic [vda_pkg::sq_width(GUARD_BITS)-1:0] sq_x,
	input  logic [vda_pkg::sq_width(GUARD_BITS)-1:0] sq_y,
	input  logic [vda_pkg::sq_width(GUARD_BITS)-1:0] sq_z,
	input  logic [vda_pkg::CFG_W-1:0]                threshold,
	input  logic                                     out_stall,
	output logic                                     fire,
	output logic                                     out_valid,
	output vda_pkg::result_t                         out_data
);

	localparam int SUM_W = vda_pkg::sum_width(GUARD_BITS);
	localparam int TH_W = vda_pkg::CFG_W + GUARD_BITS;

	vda_pkg::act_state_t state_q;
	vda_pkg::act_state_t state_next;

	logic [SUM_W-1:0]  total;
	logic [TH_W-1:0]   th;
	logic [2*TH_W-1:0] th2_q;
	logic [SUM_W-1:0]  th2_ext;
	logic              above;
	logic              below;
	logic              rep_event;
	logic              rep_q;
	logic              rep_next;

	assign total = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
	assign th = TH_W'(threshold) << GUARD_BITS;
	assign th2_ext = SUM_W'(th2_q);
	assign above = total > th2_ext;
	assign below = total < th2_ext;

	// a last item needs the result register free or being emptied
	assign fire = req.valid && (!req.last || !out_valid || !out_stall);

	always_comb begin
		case (state_q)
			vda_pkg::ST_RESTING: state_next = above ? vda_pkg::ST_ACTIVE : vda_pkg::ST_RESTING;
			vda_pkg::ST_ACTIVE:  state_next = below ? vda_pkg::ST_RESTING : vda_pkg::ST_ACTIVE;
			default:             state_next = vda_pkg::ST_RESTING;
		endcase
	end

	always_comb begin
		rep_event = (state_q == vda_pkg::ST_ACTIVE) && below;
		rep_next = rep_q || rep_event;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vda_pkg::ST_RESTING;
			rep_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (fire) begin
				state_q <= state_next;
				rep_q <= req.last ? 1'b0 : rep_next;
			end
			if (fire && req.last) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		th2_q <= th * th;
		if (fire && req.last) begin
			out_data.repetition_done <= rep_next;
			out_data.is_active <= (state_next == vda_pkg::ST_ACTIVE);
		end
	end

endmodule

@@ bench/tb_vedba_activity_detector.sv @@
// tb_vedba_activity_detector: self-checking bench for the activity detector top level
// predicts gravity tracking, the resting/active machine and batch results per sample
// depends on vda_pkg and vedba_activity_detector
module tb_vedba_activity_detector;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GUARD = vda_pkg::GUARD_BITS_DEFAULT;
	localparam int SW = vda_pkg::SAMPLE_WIDTH;
	localparam int GRAV_W = SW + GUARD;
	localparam longint GRAV_MAX = (longint'(1) <<< (GRAV_W - 1)) - 1;
	localparam longint GRAV_MIN = -GRAV_MAX - 1;
	localparam longint ONE_G = longint'(1) <<< (SW - vda_pkg::INT_BITS + GUARD);
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 80;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_BATCHES = 15;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	vda_pkg::sample_t in_data;
	logic out_valid;
	logic out_stall;
	vda_pkg::result_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [vda_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [vda_pkg::CFG_W-1:0] cfg_data;

	// model state
	longint grav_est[3];
	vda_pkg::act_state_t motion_state;
	bit rep_seen;
	logic [vda_pkg::CFG_W-1:0] weight_m;
	logic [vda_pkg::CFG_W-1:0] thresh_m;

	vda_pkg::result_t pending_results[$];
	int error_count;
	int idle_cycles;
	bit quiet;
	bit hold_request;

	vedba_activity_detector uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// gravity update for one axis, returns the squared dynamic remainder
	function automatic longint axis_energy(inout longint grav,
			input logic signed [SW-1:0] s);
		longint acc;
		longint diff;
		longint prod;
		longint rem;
		acc = longint'(s) <<< GUARD;
		diff = acc - grav;
		prod = diff * longint'(weight_m) + 32768;
		grav = grav + (prod >>> 16);
		if (grav > GRAV_MAX) begin
			grav = GRAV_MAX;
		end else if (grav < GRAV_MIN) begin
			grav = GRAV_MIN;
		end
		rem = acc - grav;
		if (rem < 0) begin
			rem = -rem;
		end
		return rem * rem;
	endfunction

	function automatic void track_sample(vda_pkg::sample_t s);
		longint energy;
		longint th;
		vda_pkg::result_t r;
		th = longint'(thresh_m) <<< GUARD;
		energy = axis_energy(grav_est[0], s.accel_x);
		energy += axis_energy(grav_est[1], s.accel_y);
		energy += axis_energy(grav_est[2], s.accel_z);
		if (motion_state == vda_pkg::ST_RESTING) begin
			if (energy > th * th) begin
				motion_state = vda_pkg::ST_ACTIVE;
			end
		end else if (energy < th * th) begin
			motion_state = vda_pkg::ST_RESTING;
			rep_seen = 1'b1;
		end
		if (s.last_in_batch) begin
			r.repetition_done = rep_seen;
			r.is_active = (motion_state == vda_pkg::ST_ACTIVE);
			pending_results.push_back(r);
			rep_seen = 1'b0;
		end
	endfunction

	function automatic vda_pkg::sample_t make_sample(int x, int y, int z, bit last);
		vda_pkg::sample_t s;
		s.accel_x = x[SW-1:0];
		s.accel_y = y[SW-1:0];
		s.accel_z = z[SW-1:0];
		s.last_in_batch = last;
		return s;
	endfunction

	// kind 0: near rest, 1: movement, 2: full-range noise
	function automatic vda_pkg::sample_t random_sample(int kind, bit last);
		int x;
		int y;
		int z;
		case (kind)
			0: begin
				x = int'($urandom_range(0, 120)) - 60;
				y = int'($urandom_range(0, 120)) - 60;
				z = 4096 + int'($urandom_range(0, 120)) - 60;
			end
			1: begin
				x = int'($urandom_range(0, 14000)) - 7000;
				y = int'($urandom_range(0, 14000)) - 7000;
				z = 4096 + int'($urandom_range(0, 14000)) - 7000;
			end
			default: begin
				x = int'($urandom());
				y = int'($urandom());
				z = int'($urandom());
			end
		endcase
		return make_sample(x, y, z, last);
	endfunction

	task automatic send_sample(vda_pkg::sample_t s);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= s;
		do @(posedge clk); while (in_stall);
		track_sample(s);
	endtask

	task automatic write_reg(logic [vda_pkg::CFG_IDX_W-1:0] idx,
			logic [vda_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			vda_pkg::REG_SMOOTHING_WEIGHT: weight_m = val;
			vda_pkg::REG_ACTIVITY_THRESHOLD: thresh_m = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// non-last samples leave no trace in the queue, so let the lanes settle too
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_registers(logic [vda_pkg::CFG_W-1:0] weight,
			logic [vda_pkg::CFG_W-1:0] thresh);
		wait_for_results();
		write_reg(vda_pkg::REG_SMOOTHING_WEIGHT, weight);
		write_reg(vda_pkg::REG_ACTIVITY_THRESHOLD, thresh);
	endtask

	function automatic void report_mismatch(vda_pkg::result_t want, vda_pkg::result_t got);
		error_count++;
		if (error_count <= 10) begin
			$display("mismatch at %0t: expected rep=%0b active=%0b, got rep=%0b active=%0b",
				$realtime, want.repetition_done, want.is_active,
				got.repetition_done, got.is_active);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		vda_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 10) begin
					$display("unexpected result at %0t: rep=%0b active=%0b",
						$realtime, out_data.repetition_done, out_data.is_active);
				end
			end else begin
				want = pending_results.pop_front();
				if (out_data.repetition_done !== want.repetition_done ||
						out_data.is_active !== want.is_active) begin
					report_mismatch(want, out_data);
				end
			end
		end
	end

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result receiver, stall per result: long on request, none when quiet, else drawn
	initial begin : result_sink
		int hold_cycles;
		out_stall = 1'b0;
		forever begin
			if (hold_request) begin
				hold_cycles = LONG_HOLD;
				hold_request = 1'b0;
			end else if (quiet) begin
				hold_cycles = 0;
			end else begin
				hold_cycles = $urandom_range(0, 3);
			end
			@(negedge clk);
			out_stall <= (hold_cycles != 0);
			if (hold_cycles != 0) begin
				repeat (hold_cycles - 1) @(negedge clk);
				@(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// frozen gravity at (0, 0, 1 g) makes magnitudes exact, so equality can be hit
	task automatic test_threshold_edges();
		// a near-full weight pulls gravity back to (0, 0, 1 g) in two samples
		set_registers(16'd65535, 16'd819);
		send_sample(make_sample(0, 0, 4096, 1'b0));
		send_sample(make_sample(0, 0, 4096, 1'b1));
		set_registers(16'd0, 16'd819);
		send_sample(make_sample(0, 0, 4096, 1'b1));
		send_sample(make_sample(819, 0, 4096, 1'b1));
		send_sample(make_sample(0, -820, 4096, 1'b0));
		send_sample(make_sample(-819, 0, 4096, 1'b1));
		send_sample(make_sample(0, 0, 4096, 1'b1));
		send_sample(make_sample(0, 0, 4096, 1'b1));
		// repetition finished on a non-last sample is still reported at the last one
		send_sample(make_sample(0, 0, 8000, 1'b0));
		send_sample(make_sample(0, 0, 4096, 1'b0));
		send_sample(make_sample(0, 819, 4096, 1'b1));
	endtask

	task automatic test_field_extremes();
		wait_for_results();
		// unused register indexes must not touch anything
		write_reg(vda_pkg::CFG_IDX_W'(2), vda_pkg::CFG_W'($urandom()));
		write_reg(vda_pkg::CFG_IDX_W'(3), vda_pkg::CFG_W'($urandom()));
		set_registers(16'hFFFF, 16'hFFFF);
		send_sample(make_sample(32767, 32767, 32767, 1'b0));
		send_sample(make_sample(-32768, -32768, -32768, 1'b1));
		send_sample(make_sample(32767, -32768, 0, 1'b1));
		send_sample(make_sample(0, 0, 0, 1'b1));
		set_registers(16'd65535, 16'd0);
		send_sample(make_sample(-32768, 32767, -32768, 1'b1));
		send_sample(make_sample(0, 0, 4096, 1'b1));
		set_registers(vda_pkg::SMOOTHING_WEIGHT_RESET, vda_pkg::ACTIVITY_THRESHOLD_RESET);
		send_sample(make_sample(32767, 0, 4096, 1'b0));
		send_sample(make_sample(0, 0, 4096, 1'b1));
		send_sample(make_sample(-1, -1, -1, 1'b1));
	endtask

	// rest, movement, rest, or at times random kinds; the last sample closes the batch
	task automatic send_batch();
		int n_lead;
		int n_move;
		int n_tail;
		int total;
		int k;
		int kind;
		if ($urandom_range(0, 99) < 15) begin
			total = $urandom_range(1, 6);
			for (k = 0; k < total; k++) begin
				kind = $urandom_range(0, 2);
				send_sample(random_sample(kind, k == total - 1));
			end
		end else begin
			n_lead = $urandom_range(0, 2);
			n_move = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
			n_tail = $urandom_range(1, 3);
			total = n_lead + n_move + n_tail;
			for (k = 0; k < total; k++) begin
				kind = (k >= n_lead && k < n_lead + n_move) ? 1 : 0;
				send_sample(random_sample(kind, k == total - 1));
			end
		end
	endtask

	task automatic test_random_batches();
		int phase;
		int b;
		logic [vda_pkg::CFG_W-1:0] weights[6];
		logic [vda_pkg::CFG_W-1:0] thresholds[6];
		weights = '{vda_pkg::SMOOTHING_WEIGHT_RESET, 16'd0, 16'd65535, 16'd65535,
			16'd3000, 16'd0};
		thresholds = '{vda_pkg::ACTIVITY_THRESHOLD_RESET, 16'd819, 16'd0, 16'd65535,
			16'd400, 16'd0};
		weights[5] = vda_pkg::CFG_W'($urandom());
		thresholds[5] = vda_pkg::CFG_W'($urandom_range(0, 4000));
		for (phase = 0; phase < 6; phase++) begin
			set_registers(weights[phase], thresholds[phase]);
			quiet = (phase == 4);
			for (b = 0; b < RANDOM_BATCHES; b++) begin
				send_batch();
			end
		end
		quiet = 1'b0;
	endtask

	// receiver holds off while the sender keeps pushing last samples
	task automatic test_backpressure();
		int k;
		set_registers(vda_pkg::SMOOTHING_WEIGHT_RESET, vda_pkg::ACTIVITY_THRESHOLD_RESET);
		quiet = 1'b1;
		hold_request = 1'b1;
		for (k = 0; k < 40; k++) begin
			send_sample(random_sample($urandom_range(0, 1), 1'b1));
		end
		wait_for_results();
		quiet = 1'b0;
		for (k = 0; k < 8; k++) begin
			send_sample(random_sample($urandom_range(0, 1), k[0]));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_request = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		weight_m = vda_pkg::SMOOTHING_WEIGHT_RESET;
		thresh_m = vda_pkg::ACTIVITY_THRESHOLD_RESET;
		grav_est[0] = 0;
		grav_est[1] = 0;
		grav_est[2] = ONE_G;
		motion_state = vda_pkg::ST_RESTING;
		rep_seen = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset values first, before any register write
		send_sample(make_sample(0, 0, 4096, 1'b1));
		send_sample(make_sample(3000, 0, 4096, 1'b1));
		test_threshold_edges();
		test_field_extremes();
		test_random_batches();
		test_backpressure();

		wait_for_results();
		error_count += pending_results.size();
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
